/* src/lpg_pkg.sv */
// line pixel generator: shared constants, config register codes, divider request/response
// types and the window side helper
// no dependencies
package lpg_pkg;

	localparam int CRD_W = 15;
	localparam int DIF_W = 16;
	localparam int NUM_W = 32;
	localparam int DEN_W = 16;
	localparam int CFG_W = 7;
	localparam int CFG_IDX_W = 1;
	localparam int DEF_MAX_SIDE = 64;
	localparam int DEF_COLOR_BITS = 32;
	localparam logic [CFG_W-1:0] WIN_RESET = 7'd64;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] dividend;
		logic [DEN_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [NUM_W-1:0] quot;
		logic [DEN_W-1:0] rem;
	} div_rsp_t;

	// zero reads as one, anything above the maximum saturates
	function automatic int side_of(input logic [CFG_W-1:0] raw, input int max_side);
		int v;
		v = int'(raw);
		if (v == 0) begin
			v = 1;
		end
		if (v > max_side) begin
			v = max_side;
		end
		return v;
	endfunction

endpackage

/* src/lpg_div.sv */
// line pixel generator: iterative unsigned restoring divider, one quotient bit per cycle
// depends on lpg_pkg
module lpg_div (
	input  logic              clk,
	input  logic              arst_n,
	input  lpg_pkg::div_req_t req,
	output lpg_pkg::div_rsp_t rsp
);
	import lpg_pkg::*;

	localparam int CNT_W = $clog2(NUM_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;

	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             fits;
	logic             last_step;

	always_comb begin
		trial     = {rem_q, quo_q[NUM_W-1]};
		fits      = trial >= {1'b0, den_q};
		diff      = trial - {1'b0, den_q};
		last_step = cnt_q == CNT_W'(NUM_W - 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && last_step;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (last_step) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			den_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[NUM_W-2:0], fits};
			rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;
	assign rsp.rem  = rem_q;

endmodule

/* src/lpg_pixel_out.sv */
// line pixel generator: address stage and output register of the pixel stream
// no package dependencies
module lpg_pixel_out #(
	parameter  int CW = 6,
	parameter  int SW = 7,
	parameter  int COLOR_BITS = 32,
	localparam int AW = 2 * CW,
	localparam int OUT_W = ((4 * CW + COLOR_BITS + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pix_valid,
	output logic                  pix_ready,
	input  logic [CW-1:0]         pix_x,
	input  logic [CW-1:0]         pix_y,
	input  logic                  pix_last,
	input  logic [COLOR_BITS-1:0] pix_color,
	input  logic [SW-1:0]         win_w,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_W-1:0]      m_axis_tdata,  // pixel_x, pixel_y, pixel_address, pixel_color
	output logic                  m_axis_tlast   // last_pixel
);

	logic                  valid_s1;
	logic [CW-1:0]         x_s1;
	logic [CW-1:0]         y_s1;
	logic                  last_s1;
	logic [COLOR_BITS-1:0] color_s1;

	logic                  valid_q;
	logic [CW-1:0]         x_q;
	logic [CW-1:0]         y_q;
	logic [AW-1:0]         addr_q;
	logic                  last_q;
	logic [COLOR_BITS-1:0] color_q;

	logic                  adv_out;
	logic [CW+SW-1:0]      row_base;
	logic [AW-1:0]         addr_c;

	always_comb begin
		adv_out   = !valid_q || m_axis_tready;
		pix_ready = !valid_s1 || adv_out;
		row_base  = (CW + SW)'(y_s1) * (CW + SW)'(win_w);
		addr_c    = row_base[AW-1:0] + AW'(x_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (pix_ready) begin
				valid_s1 <= pix_valid;
			end
			if (adv_out) begin
				valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pix_ready) begin
			x_s1     <= pix_x;
			y_s1     <= pix_y;
			last_s1  <= pix_last;
			color_s1 <= pix_color;
		end
		if (adv_out) begin
			x_q     <= x_s1;
			y_q     <= y_s1;
			addr_q  <= addr_c;
			last_q  <= last_s1;
			color_q <= color_s1;
		end
	end

	always_comb begin
		m_axis_tdata                                = '0;
		m_axis_tdata[CW-1:0]                        = x_q;
		m_axis_tdata[2*CW-1:CW]                     = y_q;
		m_axis_tdata[4*CW-1:2*CW]                   = addr_q;
		m_axis_tdata[4*CW+COLOR_BITS-1:4*CW]        = color_q;
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tlast  = last_q;

endmodule

/* src/line_pixel_generator_core.sv */
// line pixel generator top level: command sequencer, shared multiplier and minor-axis walker
// depends on lpg_pkg, lpg_div, lpg_pixel_out
//
//   channel   dir  handshake                   payload
//   s_axis    in   s_axis_tvalid/tready        start_x, start_y, end_x, end_y, line_color
//   m_axis    out  m_axis_tvalid/tready        pixel_x, pixel_y, pixel_address, pixel_color, tlast
//   cfg       in   cfg_we                      cfg_index, cfg_data
//
// a command runs through the setup states LOAD, CROSS and NUM on the one shared 16x16 multiplier,
// then SUM and SIGN, then the bit-serial divider that seeds the walk, then emits one pixel
// per cycle while m_axis does not stall; an empty span returns to idle from NUM
// s_axis_tready is high only while idle; an m_axis stall holds the walker in place
// reset brings both window registers to 64 and clears all control state
module line_pixel_generator_core #(
	parameter  int MAX_SIDE = lpg_pkg::DEF_MAX_SIDE,
	parameter  int COLOR_BITS = lpg_pkg::DEF_COLOR_BITS,
	localparam int CW = $clog2(MAX_SIDE),
	localparam int SW = $clog2(MAX_SIDE + 1),
	localparam int IN_W = ((4 * lpg_pkg::CRD_W + COLOR_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((4 * CW + COLOR_BITS + 7) / 8) * 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [lpg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lpg_pkg::CFG_W-1:0]      cfg_data,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [IN_W-1:0]                s_axis_tdata,  // start_x, start_y, end_x, end_y, line_color
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [OUT_W-1:0]               m_axis_tdata,  // pixel_x, pixel_y, pixel_address, pixel_color
	output logic                           m_axis_tlast   // last_pixel
);
	import lpg_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_LOAD  = 8'b0000_0010,
		S_CROSS = 8'b0000_0100,
		S_NUM   = 8'b0000_1000,
		S_SUM   = 8'b0001_0000,
		S_SIGN  = 8'b0010_0000,
		S_DIV   = 8'b0100_0000,
		S_WALK  = 8'b1000_0000
	} state_t;

	state_t                  state_q;
	logic [CFG_W-1:0]        win_w_q;
	logic [CFG_W-1:0]        win_h_q;
	logic [SW-1:0]           side_w;
	logic [SW-1:0]           side_h;

	logic signed [CRD_W-1:0] ax_q, ay_q, bx_q, by_q;
	logic signed [CRD_W-1:0] xmin_q, xmax_q, ymin_q, ymax_q;
	logic [COLOR_BITS-1:0]   color_q;
	logic signed [DIF_W-1:0] dx_q, dy_q, step_q;
	logic [DEN_W-1:0]        den_q;
	logic                    nsign_q;
	logic                    x_major_q;
	logic [CW-1:0]           lo_q, hi_q, m_q;
	logic signed [NUM_W-1:0] prod_q, cross_q, num_q;
	logic signed [NUM_W:0]   q_q;
	logic [DEN_W-1:0]        r_q;

	logic signed [CRD_W-1:0] in_ax, in_ay, in_bx, in_by;
	logic [COLOR_BITS-1:0]   in_color;
	logic                    in_fire;

	logic [DIF_W-1:0]        abs_dx, abs_dy;
	logic                    maj_c;
	logic [CW-1:0]           xlo_c, xhi_c, ylo_c, yhi_c;
	logic signed [DIF_W-1:0] mul_a, mul_b;
	logic signed [NUM_W-1:0] mul_p;
	logic signed [DIF_W-1:0] s_c, dv_c;
	logic [NUM_W-1:0]        abs_num;

	div_req_t                div_req;
	div_rsp_t                div_rsp;
	logic signed [NUM_W:0]   q_fix;
	logic [DEN_W-1:0]        r_fix;

	logic [SW-1:0]           minor_side;
	logic [CW-1:0]           minor_lim;
	logic [CW-1:0]           minor_c;
	logic                    last_c;
	logic signed [DEN_W+1:0] r_sum;
	logic signed [DEN_W+1:0] den_ext;
	logic [DEN_W-1:0]        r_nxt;
	logic signed [NUM_W:0]   q_nxt;

	logic                    pix_valid;
	logic                    pix_ready;
	logic [CW-1:0]           pix_x, pix_y;

	function automatic logic [CW-1:0] clamp_crd(input logic signed [CRD_W-1:0] v,
			input logic [SW-1:0] side);
		logic signed [CRD_W:0] lim;
		logic signed [CRD_W:0] vx;
		logic [CW-1:0]         res;
		lim = $signed({{(CRD_W + 1 - SW){1'b0}}, side}) - (CRD_W + 1)'(1);
		vx  = {v[CRD_W-1], v};
		if (vx < 0) begin
			res = '0;
		end else if (vx > lim) begin
			res = lim[CW-1:0];
		end else begin
			res = vx[CW-1:0];
		end
		return res;
	endfunction

	// input unpack and window sides
	always_comb begin
		in_ax    = s_axis_tdata[CRD_W-1:0];
		in_ay    = s_axis_tdata[2*CRD_W-1:CRD_W];
		in_bx    = s_axis_tdata[3*CRD_W-1:2*CRD_W];
		in_by    = s_axis_tdata[4*CRD_W-1:3*CRD_W];
		in_color = s_axis_tdata[4*CRD_W+COLOR_BITS-1:4*CRD_W];
		side_w   = SW'(side_of(win_w_q, MAX_SIDE));
		side_h   = SW'(side_of(win_h_q, MAX_SIDE));
	end

	assign s_axis_tready = state_q == S_IDLE;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	// setup datapath
	always_comb begin
		abs_dx = dx_q[DIF_W-1] ? DIF_W'(-dx_q) : dx_q;
		abs_dy = dy_q[DIF_W-1] ? DIF_W'(-dy_q) : dy_q;
		maj_c  = abs_dx >= abs_dy;
		xlo_c  = clamp_crd(xmin_q, side_w);
		xhi_c  = clamp_crd(xmax_q, side_w);
		ylo_c  = clamp_crd(ymin_q, side_h);
		yhi_c  = clamp_crd(ymax_q, side_h);
		s_c    = x_major_q ? dy_q : dx_q;
		dv_c   = x_major_q ? dx_q : dy_q;
		abs_num = num_q[NUM_W-1] ? NUM_W'(-num_q) : num_q;
	end

	// shared multiplier operand select
	always_comb begin
		case (state_q)
			S_LOAD: begin
				mul_a = {bx_q[CRD_W-1], bx_q};
				mul_b = {ay_q[CRD_W-1], ay_q};
			end
			S_CROSS: begin
				mul_a = {ax_q[CRD_W-1], ax_q};
				mul_b = {by_q[CRD_W-1], by_q};
			end
			default: begin
				mul_a = s_c;
				mul_b = $signed(DIF_W'(lo_q));
			end
		endcase
		mul_p = NUM_W'(mul_a) * NUM_W'(mul_b);
	end

	// divider seed and floor correction
	always_comb begin
		div_req.start    = state_q == S_SIGN;
		div_req.dividend = abs_num;
		div_req.divisor  = den_q;
		if (!nsign_q) begin
			q_fix = $signed({1'b0, div_rsp.quot});
			r_fix = div_rsp.rem;
		end else if (div_rsp.rem == '0) begin
			q_fix = -$signed({1'b0, div_rsp.quot});
			r_fix = '0;
		end else begin
			q_fix = ~$signed({1'b0, div_rsp.quot});
			r_fix = den_q - div_rsp.rem;
		end
	end

	// walker: floor quotient and remainder step by one major position
	always_comb begin
		minor_side = x_major_q ? side_h : side_w;
		minor_lim  = CW'(minor_side - SW'(1));
		if (q_q[NUM_W]) begin
			minor_c = '0;
		end else if (q_q[NUM_W-1:0] > NUM_W'(minor_lim)) begin
			minor_c = minor_lim;
		end else begin
			minor_c = q_q[CW-1:0];
		end
		pix_x   = x_major_q ? m_q : minor_c;
		pix_y   = x_major_q ? minor_c : m_q;
		last_c  = ({1'b0, m_q} + (CW + 1)'(1)) == {1'b0, hi_q};
		den_ext = $signed({2'b00, den_q});
		r_sum   = $signed({2'b00, r_q}) + {{2{step_q[DIF_W-1]}}, step_q};
		if (r_sum >= den_ext) begin
			r_nxt = DEN_W'(r_sum - den_ext);
			q_nxt = q_q + (NUM_W + 1)'(1);
		end else if (r_sum[DEN_W+1]) begin
			r_nxt = DEN_W'(r_sum + den_ext);
			q_nxt = q_q - (NUM_W + 1)'(1);
		end else begin
			r_nxt = r_sum[DEN_W-1:0];
			q_nxt = q_q;
		end
	end

	assign pix_valid = state_q == S_WALK;

	// sequencer and config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			win_w_q <= WIN_RESET;
			win_h_q <= WIN_RESET;
		end else begin
			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_WIDTH:  win_w_q <= cfg_data;
					REG_HEIGHT: win_h_q <= cfg_data;
					default:    ;
				endcase
			end
			unique case (state_q)
				S_IDLE:  if (in_fire) begin
					state_q <= S_LOAD;
				end
				S_LOAD:  state_q <= S_CROSS;
				S_CROSS: state_q <= S_NUM;
				S_NUM:   state_q <= (lo_q == hi_q) ? S_IDLE : S_SUM;
				S_SUM:   state_q <= S_SIGN;
				S_SIGN:  state_q <= S_DIV;
				S_DIV:   if (div_rsp.done) begin
					state_q <= S_WALK;
				end
				S_WALK:  if (pix_ready && last_c) begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// command datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					ax_q    <= in_ax;
					ay_q    <= in_ay;
					bx_q    <= in_bx;
					by_q    <= in_by;
					color_q <= in_color;
				end
			end
			S_LOAD: begin
				dx_q   <= {bx_q[CRD_W-1], bx_q} - {ax_q[CRD_W-1], ax_q};
				dy_q   <= {by_q[CRD_W-1], by_q} - {ay_q[CRD_W-1], ay_q};
				xmin_q <= (ax_q < bx_q) ? ax_q : bx_q;
				xmax_q <= (ax_q < bx_q) ? bx_q : ax_q;
				ymin_q <= (ay_q < by_q) ? ay_q : by_q;
				ymax_q <= (ay_q < by_q) ? by_q : ay_q;
				prod_q <= mul_p;
			end
			S_CROSS: begin
				cross_q   <= prod_q;
				prod_q    <= mul_p;
				x_major_q <= maj_c;
				lo_q      <= maj_c ? xlo_c : ylo_c;
				hi_q      <= maj_c ? xhi_c : yhi_c;
			end
			S_NUM: begin
				cross_q <= cross_q - prod_q;
				prod_q  <= mul_p;
				den_q   <= dv_c[DIF_W-1] ? DEN_W'(-dv_c) : DEN_W'(dv_c);
				step_q  <= dv_c[DIF_W-1] ? -s_c : s_c;
				nsign_q <= dv_c[DIF_W-1];
			end
			S_SUM: begin
				num_q <= x_major_q ? prod_q + cross_q : prod_q - cross_q;
			end
			S_SIGN: begin
				nsign_q <= num_q[NUM_W-1] ^ nsign_q;
			end
			S_DIV: begin
				if (div_rsp.done) begin
					q_q <= q_fix;
					r_q <= r_fix;
					m_q <= lo_q;
				end
			end
			S_WALK: begin
				if (pix_ready) begin
					q_q <= q_nxt;
					r_q <= r_nxt;
					m_q <= m_q + CW'(1);
				end
			end
			default: ;
		endcase
	end

	lpg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	lpg_pixel_out #(
		.CW         (CW),
		.SW         (SW),
		.COLOR_BITS (COLOR_BITS)
	) u_pixel_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.pix_valid     (pix_valid),
		.pix_ready     (pix_ready),
		.pix_x         (pix_x),
		.pix_y         (pix_y),
		.pix_last      (last_c),
		.pix_color     (color_q),
		.win_w         (side_w),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

/* src/lpg_checker.sv */
// line pixel generator: port-level checker and its bind to the top level
// depends on lpg_pkg and line_pixel_generator_core
module lpg_checker #(
	parameter  int MAX_SIDE = lpg_pkg::DEF_MAX_SIDE,
	parameter  int COLOR_BITS = lpg_pkg::DEF_COLOR_BITS,
	localparam int CW = $clog2(MAX_SIDE),
	localparam int SW = $clog2(MAX_SIDE + 1),
	localparam int AW = 2 * CW,
	localparam int OUT_W = ((4 * CW + COLOR_BITS + 7) / 8) * 8
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          cfg_we,
	input logic [lpg_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [lpg_pkg::CFG_W-1:0]     cfg_data,
	input logic                          s_axis_tvalid,
	input logic                          s_axis_tready,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [OUT_W-1:0]              m_axis_tdata,
	input logic                          m_axis_tlast
);
	import lpg_pkg::*;

	logic [CFG_W-1:0] win_w_q;
	logic [CFG_W-1:0] win_h_q;
	logic [SW-1:0]    side_w;
	logic [SW-1:0]    side_h;
	logic [CW-1:0]    px;
	logic [CW-1:0]    py;
	logic [AW-1:0]    pa;
	logic [CW+SW-1:0] row_base;
	logic [AW-1:0]    exp_addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_w_q <= WIN_RESET;
			win_h_q <= WIN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_WIDTH:  win_w_q <= cfg_data;
				REG_HEIGHT: win_h_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	always_comb begin
		side_w   = SW'(side_of(win_w_q, MAX_SIDE));
		side_h   = SW'(side_of(win_h_q, MAX_SIDE));
		px       = m_axis_tdata[CW-1:0];
		py       = m_axis_tdata[2*CW-1:CW];
		pa       = m_axis_tdata[4*CW-1:2*CW];
		row_base = (CW + SW)'(py) * (CW + SW)'(side_w);
		exp_addr = row_base[AW-1:0] + AW'(px);
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output word changed while stalled");

	a_busy_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("command port still ready after taking a command");

	a_addr: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> pa == exp_addr)
		else $error("pixel address does not match x plus y times width");

	a_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (SW'(px) < side_w) && (SW'(py) < side_h))
		else $error("pixel outside the window");

endmodule

bind line_pixel_generator_core lpg_checker #(
	.MAX_SIDE   (MAX_SIDE),
	.COLOR_BITS (COLOR_BITS)
) u_lpg_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cfg_we        (cfg_we),
	.cfg_index     (cfg_index),
	.cfg_data      (cfg_data),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);

/* tb/testbench.sv */
`timescale 1ns / 100ps
// testbench for line_pixel_generator_core: random and directed line commands, pixel-by-pixel
// comparison against an in-bench rasterizer held in a small scoreboard class
// depends on lpg_pkg and line_pixel_generator_core
module testbench;
	import lpg_pkg::*;

	localparam int IN_BITS = 96;
	localparam int OUT_BITS = 56;

	typedef struct {
		logic signed [14:0] sx;
		logic signed [14:0] sy;
		logic signed [14:0] ex;
		logic signed [14:0] ey;
		logic [31:0]        color;
	} line_cmd_t;

	typedef struct {
		logic [5:0]  x;
		logic [5:0]  y;
		logic [11:0] addr;
		logic [31:0] color;
		logic        last;
	} pixel_t;

	class line_tracker;
		pixel_t pending_pixels[$];
		int mismatch_count;
		logic [CFG_W-1:0] width_reg;
		logic [CFG_W-1:0] height_reg;

		function new();
			mismatch_count = 0;
			width_reg = 7'd64;
			height_reg = 7'd64;
		endfunction

		function void set_window(cfg_reg_t idx, logic [CFG_W-1:0] v);
			if (idx == REG_WIDTH) begin
				width_reg = v;
			end else begin
				height_reg = v;
			end
		endfunction

		function longint clip_side(logic [CFG_W-1:0] raw);
			longint v;
			v = longint'(raw);
			if (v == 0) begin
				v = 1;
			end
			if (v > 64) begin
				v = 64;
			end
			return v;
		endfunction

		function longint clamp(longint v, longint lo, longint hi);
			if (v < lo) begin
				return lo;
			end
			if (v > hi) begin
				return hi;
			end
			return v;
		endfunction

		// rasterize one command into the pixels the block should emit
		function void note_line(line_cmd_t c);
			longint ax, ay, bx, by, w, h;
			longint xlo, xhi, ylo, yhi, dx, dy, adx, ady, cross_term, lo, hi, m, px, py;
			bit x_major;
			pixel_t p;
			ax = c.sx;
			ay = c.sy;
			bx = c.ex;
			by = c.ey;
			w = clip_side(width_reg);
			h = clip_side(height_reg);
			xlo = clamp((ax < bx) ? ax : bx, 0, w - 1);
			xhi = clamp((ax < bx) ? bx : ax, 0, w - 1);
			ylo = clamp((ay < by) ? ay : by, 0, h - 1);
			yhi = clamp((ay < by) ? by : ay, 0, h - 1);
			dx = bx - ax;
			dy = by - ay;
			adx = (dx < 0) ? -dx : dx;
			ady = (dy < 0) ? -dy : dy;
			cross_term = bx * ay - ax * by;
			x_major = (adx >= ady);
			lo = x_major ? xlo : ylo;
			hi = x_major ? xhi : yhi;
			for (m = lo; m < hi; m++) begin
				if (x_major) begin
					px = m;
					py = (dx != 0) ? (dy * m + cross_term) / dx : 0;
					py = clamp(py, 0, h - 1);
				end else begin
					py = m;
					px = (dy != 0) ? (dx * m - cross_term) / dy : 0;
					px = clamp(px, 0, w - 1);
				end
				p.x = px[5:0];
				p.y = py[5:0];
				p.addr = 12'(px + py * w);
				p.color = c.color;
				p.last = (m + 1 == hi);
				pending_pixels.push_back(p);
			end
		endfunction

		task report_mismatch(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			mismatch_count++;
		endtask

		task check_pixel(pixel_t got);
			pixel_t want;
			if (pending_pixels.size() == 0) begin
				report_mismatch($sformatf("unexpected word x=%0d y=%0d addr=%0d color=%h last=%0b",
					got.x, got.y, got.addr, got.color, got.last));
				return;
			end
			want = pending_pixels.pop_front();
			if (got.x !== want.x || got.y !== want.y || got.addr !== want.addr ||
				got.color !== want.color || got.last !== want.last) begin
				report_mismatch($sformatf({"got x=%0d y=%0d addr=%0d color=%h last=%0b, ",
					"want x=%0d y=%0d addr=%0d color=%h last=%0b"},
					got.x, got.y, got.addr, got.color, got.last,
					want.x, want.y, want.addr, want.color, want.last));
			end
		endtask
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [IN_BITS-1:0]   s_axis_tdata;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [OUT_BITS-1:0]  m_axis_tdata;
	logic                 m_axis_tlast;

	int send_idle_pct;
	int recv_stall_pct;
	line_tracker tracker;

	line_pixel_generator_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#(4_000_000);
		$display("FAILED: results differ");
		$finish;
	end

	// pixel sink with random stalls
	initial begin
		pixel_t got;
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready) begin
				got.x = m_axis_tdata[5:0];
				got.y = m_axis_tdata[11:6];
				got.addr = m_axis_tdata[23:12];
				got.color = m_axis_tdata[55:24];
				got.last = m_axis_tlast;
				tracker.check_pixel(got);
			end
			m_axis_tready <= (int'($urandom_range(99)) >= recv_stall_pct);
		end
	end

	task write_window(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
		cfg_we <= 1'b1;
		cfg_index <= REG_WIDTH;
		cfg_data <= w;
		@(posedge clk);
		cfg_index <= REG_HEIGHT;
		cfg_data <= h;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		tracker.set_window(REG_WIDTH, w);
		tracker.set_window(REG_HEIGHT, h);
	endtask

	// valid stays up across back-to-back words, drops only for a gap
	task send_line(input line_cmd_t c);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'b0, c.color, c.ey, c.ex, c.sy, c.sx};
		do begin
			@(posedge clk);
		end while (!s_axis_tready);
		tracker.note_line(c);
		if (int'($urandom_range(99)) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do begin
				@(posedge clk);
			end while (int'($urandom_range(99)) < send_idle_pct);
		end
	endtask

	// wait for all pixels, then let an empty span finish before touching config
	task drain;
		s_axis_tvalid <= 1'b0;
		while (tracker.pending_pixels.size() != 0) begin
			@(posedge clk);
		end
		repeat (64) @(posedge clk);
	endtask

	function automatic logic signed [14:0] pick_coord();
		case ($urandom_range(9))
			0: return 15'($urandom_range(32767));
			1, 2: return 15'(int'($urandom_range(110)) - 20);
			3: return 15'(int'($urandom_range(400)) - 200);
			default: return 15'($urandom_range(63));
		endcase
	endfunction

	task send_cmd(input int sx, input int sy, input int ex, input int ey, input logic [31:0] col);
		line_cmd_t c;
		c.sx = 15'(sx);
		c.sy = 15'(sy);
		c.ex = 15'(ex);
		c.ey = 15'(ey);
		c.color = col;
		send_line(c);
	endtask

	task run_phase(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
		input int send_pct, input int recv_pct, input int count, input int pause_at);
		line_cmd_t c;
		write_window(w, h);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		for (int i = 0; i < count; i++) begin
			if (i == pause_at) begin
				drain();
			end
			c.sx = pick_coord();
			c.sy = pick_coord();
			c.ex = pick_coord();
			c.ey = pick_coord();
			c.color = $urandom;
			send_line(c);
		end
		drain();
	endtask

	initial begin
		tracker = new();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_WIDTH;
		cfg_data <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed lines under the reset window
		send_cmd(10, 10, 10, 10, 32'h0000_0000);
		send_cmd(0, 5, 63, 5, 32'hFFFF_FFFF);
		send_cmd(7, 0, 7, 63, 32'hA5A5_5A5A);
		send_cmd(0, 0, 63, 63, 32'h5A5A_A5A5);
		send_cmd(63, 0, 0, 63, 32'h0000_0001);
		send_cmd(20, 3, 21, 4, 32'h8000_0000);
		send_cmd(20, 3, 20, 4, 32'h1234_5678);
		send_cmd(30, 30, 31, 30, 32'h0F0F_0F0F);
		send_cmd(-100, -50, -10, -40, 32'hDEAD_BEEF);
		send_cmd(100, 5, 200, 9, 32'hF0F0_F0F0);
		send_cmd(5, 100, 9, 300, 32'h3333_CCCC);
		send_cmd(-16384, -16384, 16383, 16383, 32'h0000_0000);
		send_cmd(16383, -16384, -16384, 16383, 32'hFFFF_FFFF);
		send_cmd(-16384, 16383, 16383, -16384, 32'hCCCC_3333);
		send_cmd(-5, -20, 40, 70, 32'h0000_FFFF);
		send_cmd(-30, 10, 90, 40, 32'hFFFF_0000);
		send_cmd(50, 0, 3, 63, 32'h7FFF_FFFE);
		send_cmd(63, 40, 0, 2, 32'h5555_AAAA);
		send_cmd(2, 63, 60, 61, 32'hAAAA_5555);
		send_cmd(16383, 16383, 16383, 16383, 32'h0101_0101);
		drain();

		run_phase(7'd37, 7'd64, 0, 0, 52, -1);
		run_phase(7'd64, 7'd20, 54, 0, 52, 27);
		run_phase(7'd0, 7'd127, 0, 54, 52, -1);
		run_phase(7'd127, 7'd1, 25, 25, 52, -1);
		run_phase(7'd23, 7'd64, 25, 25, 52, -1);
		run_phase(7'd64, 7'd64, 0, 0, 52, -1);

		if (tracker.mismatch_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
